// File: rtl/sctw_pkg.sv
// Shared types and constants for the script table with wildcard fallback.
// Holds table sizing, operation, status and match level codes, and the
// memory write port structure. No dependencies.
package sctw_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int KEY_W         = 48;
  localparam int HANDLE_W      = 16;
  localparam int NUM_LEVELS    = 4;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int LEVEL_W       = 2;

  localparam logic [OP_W-1:0] OP_INSTALL    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND_FB    = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_EXACT = 3'd3;
  localparam logic [OP_W-1:0] OP_LOCK       = 3'd4;
  localparam logic [OP_W-1:0] OP_UNLOCK     = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
  // The spare code is accepted and ignored.
  localparam logic [OP_W-1:0] OP_SPARE      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOCKED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic [LEVEL_W-1:0] LVL_EXACT   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_SPECIES = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_GENUS   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_FAMILY  = 2'd3;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } mem_wr_t;

endpackage

// File: rtl/sctw_mem.sv
// Key and handle storage for the script table: one write port and one
// registered read port. Depends on sctw_pkg.
module sctw_mem (
  input  logic                           clk,
  input  sctw_pkg::mem_wr_t              wr,
  input  logic [sctw_pkg::IDX_W-1:0]     rd_addr,
  output logic [sctw_pkg::KEY_W-1:0]     rd_key,
  output logic [sctw_pkg::HANDLE_W-1:0]  rd_handle
);
  import sctw_pkg::*;

  logic [KEY_W+HANDLE_W-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.key, wr.handle};
    end
  end

  always_ff @(posedge clk) begin
    {rd_key, rd_handle} <= mem[rd_addr];
  end

endmodule

// File: rtl/script_table_with_wildcard_fallback.sv
// Top level of the script table with wildcard fallback.
// Holds the sequencer, the valid and lock bits and the output register;
// depends on sctw_pkg and sctw_mem.

// The table maps a 48-bit key (family, genus, species, event) to a 16-bit
// script handle and a lock bit. Every transaction except clear and the
// unused operation code walks the whole table once through a single read
// port, one entry per cycle, comparing the stored key against the exact
// key and its three wildcard forms in parallel and noting the first free
// slot. Such a transaction keeps the input stalled from acceptance through
// the scan state (one read per entry), a drain state for the read register
// and a done state that settles and writes back, which waits while a
// stalled result holds the output register; only then is the input taken
// again. Clear and the unused code go straight to the done state.
// Valid and lock bits live in flip-flops cleared at reset and by clear;
// keys and handles live in a memory that needs no initialization. A result
// sits in an output register, so a new transaction may start while the
// previous result still waits; the result is only written once that
// register is free.
module script_table_with_wildcard_fallback (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sctw_pkg::OP_W-1:0]         operation,
  input  logic [7:0]                        family_id,
  input  logic [7:0]                        genus_id,
  input  logic [15:0]                       species_id,
  input  logic [15:0]                       event_id,
  input  logic [sctw_pkg::HANDLE_W-1:0]     script_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sctw_pkg::STATUS_W-1:0]     status,
  output logic                              found,
  output logic [sctw_pkg::HANDLE_W-1:0]     found_handle,
  output logic [sctw_pkg::LEVEL_W-1:0]      match_level
);
  import sctw_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0] state;
  logic [1:0] state_next;

  // Latched request.
  logic [OP_W-1:0]     op;
  logic [7:0]          fam;
  logic [7:0]          gen;
  logic [15:0]         spc;
  logic [15:0]         evt;
  logic [HANDLE_W-1:0] hnd;

  // Per-entry flags.
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TABLE_ENTRIES-1:0] entry_locked;

  // Scan pipeline.
  logic [IDX_W-1:0]    scan_addr;
  logic                pipe_active;
  logic [IDX_W-1:0]    pipe_idx;
  logic                pipe_entry_valid;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  // Scan results.
  logic [NUM_LEVELS-1:0] hit;
  logic [IDX_W-1:0]      hit_slot [NUM_LEVELS];
  logic [HANDLE_W-1:0]   hit_handle [NUM_LEVELS];
  logic                  free_hit;
  logic [IDX_W-1:0]      free_slot;

  logic [KEY_W-1:0] fb_key [NUM_LEVELS];

  // Finish-cycle decisions.
  logic                do_finish;
  logic                exact_locked;
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [HANDLE_W-1:0] res_handle;
  logic [LEVEL_W-1:0]  res_level;
  mem_wr_t             wr;
  logic                set_valid;
  logic                drop_valid;
  logic                set_lock;
  logic                drop_lock;
  logic                clear_all;
  logic [IDX_W-1:0]    act_idx;

  logic in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign do_finish = (state == S_DONE) && (!out_valid || !out_stall);

  // The exact key and its three wildcard forms, in fallback order.
  assign fb_key[0] = {fam, gen, spc, evt};
  assign fb_key[1] = {fam, gen, 16'd0, evt};
  assign fb_key[2] = {fam, 8'd0, 16'd0, evt};
  assign fb_key[3] = {8'd0, 8'd0, 16'd0, evt};

  sctw_mem u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (scan_addr),
    .rd_key    (rd_key),
    .rd_handle (rd_handle)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (operation == OP_CLEAR || operation == OP_SPARE) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_addr == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (do_finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pipe_active <= 1'b0;
    end else begin
      state       <= state_next;
      pipe_active <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op  <= operation;
      fam <= family_id;
      gen <= genus_id;
      spc <= species_id;
      evt <= event_id;
      hnd <= script_handle;
    end
  end

  // Read address walks the table once per transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      scan_addr <= '0;
    end else if (state == S_SCAN && scan_addr != LAST_IDX) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // The valid bit travels alongside the registered memory read.
  always_ff @(posedge clk) begin
    pipe_idx         <= scan_addr;
    pipe_entry_valid <= entry_valid[scan_addr];
  end

  // Compare stage: the first matching entry wins at each level, and the
  // first free slot is remembered for install.
  always_ff @(posedge clk) begin
    if (rst || in_accept) begin
      hit      <= '0;
      free_hit <= 1'b0;
    end else if (pipe_active) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (pipe_entry_valid && !hit[l] && rd_key == fb_key[l]) begin
          hit[l] <= 1'b1;
        end
      end
      if (!pipe_entry_valid && !free_hit) begin
        free_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_active) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (pipe_entry_valid && !hit[l] && rd_key == fb_key[l]) begin
          hit_slot[l]   <= pipe_idx;
          hit_handle[l] <= rd_handle;
        end
      end
      if (!pipe_entry_valid && !free_hit) begin
        free_slot <= pipe_idx;
      end
    end
  end

  assign exact_locked = entry_locked[hit_slot[0]];

  // Result and table update, decided once the scan has finished.
  always_comb begin
    res_status = ST_OK;
    res_found  = 1'b0;
    res_handle = '0;
    res_level  = LVL_EXACT;
    wr         = '0;
    set_valid  = 1'b0;
    drop_valid = 1'b0;
    set_lock   = 1'b0;
    drop_lock  = 1'b0;
    clear_all  = 1'b0;
    act_idx    = hit_slot[0];
    unique case (op) inside
      OP_INSTALL: begin
        if (hit[0]) begin
          if (exact_locked) begin
            res_status = ST_LOCKED;
          end else begin
            wr.en = 1'b1;
          end
        end else if (!free_hit) begin
          res_status = ST_FULL;
        end else begin
          act_idx   = free_slot;
          wr.en     = 1'b1;
          set_valid = 1'b1;
          drop_lock = 1'b1;
        end
        wr.addr   = act_idx;
        wr.key    = fb_key[0];
        wr.handle = hnd;
      end
      OP_REMOVE: begin
        if (!hit[0]) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_found  = 1'b1;
          res_handle = hit_handle[0];
          if (exact_locked) begin
            res_status = ST_LOCKED;
          end else begin
            drop_valid = 1'b1;
          end
        end
      end
      OP_FIND_FB: begin
        res_found = 1'b1;
        if (hit[0]) begin
          res_handle = hit_handle[0];
          res_level  = LVL_EXACT;
        end else if (hit[1]) begin
          res_handle = hit_handle[1];
          res_level  = LVL_SPECIES;
        end else if (hit[2]) begin
          res_handle = hit_handle[2];
          res_level  = LVL_GENUS;
        end else if (hit[3]) begin
          res_handle = hit_handle[3];
          res_level  = LVL_FAMILY;
        end else begin
          res_found  = 1'b0;
          res_status = ST_NOT_FOUND;
        end
      end
      OP_FIND_EXACT, OP_LOCK, OP_UNLOCK: begin
        if (!hit[0]) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_found  = 1'b1;
          res_handle = hit_handle[0];
          set_lock   = (op == OP_LOCK);
          drop_lock  = (op == OP_UNLOCK);
        end
      end
      OP_CLEAR: begin
        clear_all = 1'b1;
      end
      default: begin
      end
    endcase
    wr.en = wr.en && do_finish;
  end

  // Valid and lock flags; clear wipes locked entries as well.
  always_ff @(posedge clk) begin
    if (rst || (do_finish && clear_all)) begin
      entry_valid  <= '0;
      entry_locked <= '0;
    end else if (do_finish) begin
      if (set_valid) begin
        entry_valid[act_idx] <= 1'b1;
      end
      if (drop_valid) begin
        entry_valid[act_idx] <= 1'b0;
      end
      if (set_lock) begin
        entry_locked[act_idx] <= 1'b1;
      end
      if (drop_lock) begin
        entry_locked[act_idx] <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      status       <= res_status;
      found        <= res_found;
      found_handle <= res_handle;
      match_level  <= res_level;
    end
  end

endmodule

// File: rtl/sctw_checker.sv
// Port-level checks for the script table with wildcard fallback, and the
// bind that attaches them to the top level. Depends on sctw_pkg.
module sctw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [sctw_pkg::STATUS_W-1:0]     status,
  input logic                              found,
  input logic [sctw_pkg::HANDLE_W-1:0]     found_handle,
  input logic [sctw_pkg::LEVEL_W-1:0]      match_level
);
  import sctw_pkg::*;

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction was in progress");

  // A wildcard level is only reported together with a located entry.
  a_level_needs_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && match_level != LVL_EXACT) |-> (found && status == ST_OK))
    else $error("match level set without a located entry");

  // Nothing located means no handle.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (found_handle == '0))
    else $error("handle reported without a located entry");

  // A full table or not-found result never reports a located entry.
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL || status == ST_NOT_FOUND)) |-> !found)
    else $error("located entry reported with a full or absent status");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(found)
      && $stable(found_handle) && $stable(match_level)))
    else $error("stalled result changed");

endmodule

bind script_table_with_wildcard_fallback sctw_checker u_sctw_checker (.*);

// File: sim/tb_script_table_with_wildcard_fallback.sv
// Self-checking testbench for script_table_with_wildcard_fallback.
// Holds a shadow copy of the script table that predicts every reply, plus the
// stimulus and handshake drivers. Depends on sctw_pkg and the RTL top level.
module tb_script_table_with_wildcard_fallback;
  import sctw_pkg::*;

  localparam int LONG_HOLD   = 1500;     // receiver hold-off, in cycles
  localparam int SETTLE      = 300;      // one full table walk plus margin
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [HANDLE_W-1:0] hit_handle;
    logic [LEVEL_W-1:0]  level;
  } table_reply_t;

  // Shadow of the script table. Replies are predicted in acceptance order and
  // checked against the block's replies in the order they come out.
  class table_shadow;
    bit [HANDLE_W-1:0] handle_of [bit [KEY_W-1:0]];
    bit                locked_of [bit [KEY_W-1:0]];
    table_reply_t      expected_replies [$];
    int                errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic [7:0] fam, logic [7:0] gen,
                                logic [15:0] spc, logic [15:0] evt, logic [HANDLE_W-1:0] hnd);
      bit [KEY_W-1:0]     key;
      bit [KEY_W-1:0]     probe [NUM_LEVELS];
      logic [LEVEL_W-1:0] level_code [NUM_LEVELS];
      table_reply_t       r;
      key = {fam, gen, spc, evt};
      // Fallback probes widen the key one part at a time, species first.
      probe[0] = key;
      probe[1] = {fam, gen, 16'h0000, evt};
      probe[2] = {fam, 8'h00, 16'h0000, evt};
      probe[3] = {8'h00, 8'h00, 16'h0000, evt};
      level_code = '{LVL_EXACT, LVL_SPECIES, LVL_GENUS, LVL_FAMILY};
      r = '0;
      r.status = ST_OK;
      r.level  = LVL_EXACT;
      case (op)
        OP_INSTALL: begin
          if (handle_of.exists(key)) begin
            if (locked_of[key]) r.status = ST_LOCKED;
            else handle_of[key] = hnd;
          end else if (handle_of.num() >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            handle_of[key] = hnd;
            locked_of[key] = 1'b0;
          end
        end
        OP_REMOVE: begin
          if (!handle_of.exists(key)) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found      = 1'b1;
            r.hit_handle = handle_of[key];
            if (locked_of[key]) begin
              r.status = ST_LOCKED;
            end else begin
              handle_of.delete(key);
              locked_of.delete(key);
            end
          end
        end
        OP_FIND_FB: begin
          r.status = ST_NOT_FOUND;
          for (int l = 0; l < NUM_LEVELS; l++) begin
            if (!r.found && handle_of.exists(probe[l])) begin
              r.status     = ST_OK;
              r.found      = 1'b1;
              r.hit_handle = handle_of[probe[l]];
              r.level      = level_code[l];
            end
          end
        end
        OP_FIND_EXACT, OP_LOCK, OP_UNLOCK: begin
          if (!handle_of.exists(key)) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found      = 1'b1;
            r.hit_handle = handle_of[key];
            if (op == OP_LOCK) locked_of[key] = 1'b1;
            else if (op == OP_UNLOCK) locked_of[key] = 1'b0;
          end
        end
        OP_CLEAR: begin
          handle_of.delete();
          locked_of.delete();
        end
        default: begin
        end
      endcase
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic fnd, logic [HANDLE_W-1:0] hnd,
                              logic [LEVEL_W-1:0] lvl);
      table_reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $error("reply with no transaction waiting for it (status %0d)", st);
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, st);
      end
      if (fnd !== want.found) begin
        errors++;
        $error("found: expected %0d, actual %0d", want.found, fnd);
      end
      if (hnd !== want.hit_handle) begin
        errors++;
        $error("found_handle: expected 0x%04h, actual 0x%04h", want.hit_handle, hnd);
      end
      if (lvl !== want.level) begin
        errors++;
        $error("match_level: expected %0d, actual %0d", want.level, lvl);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = OP_INSTALL;
  logic [7:0]          family_id = '0;
  logic [7:0]          genus_id = '0;
  logic [15:0]         species_id = '0;
  logic [15:0]         event_id = '0;
  logic [HANDLE_W-1:0] script_handle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [HANDLE_W-1:0] found_handle;
  logic [LEVEL_W-1:0]  match_level;

  table_shadow shadow = new();

  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  // Key pool for the random part; slot zero of family, genus and species is
  // the wildcard value so that fallback finds hit every level.
  logic [7:0]  pool_fam [3];
  logic [7:0]  pool_gen [3];
  logic [15:0] pool_spc [3];
  logic [15:0] pool_evt [2];

  script_table_with_wildcard_fallback dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .family_id    (family_id),
    .genus_id     (genus_id),
    .species_id   (species_id),
    .event_id     (event_id),
    .script_handle(script_handle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found        (found),
    .found_handle (found_handle),
    .match_level  (match_level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reply side: every reply taken by the handshake is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_reply(status, found, found_handle, match_level);
  end

  // Reply stall pattern, in randomly chosen modes; a long hold-off asked for
  // by the stimulus takes precedence and is counted here.
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 400);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (mode_left % 7 < 3);
      endcase
    end
  end

  // Offers one transaction and waits until the block takes it. The prediction is
  // made at the accepting edge, so it follows acceptance order exactly.
  task automatic drive_request(input logic [OP_W-1:0] op, input logic [7:0] fam,
                               input logic [7:0] gen, input logic [15:0] spc,
                               input logic [15:0] evt, input logic [HANDLE_W-1:0] hnd);
    @(negedge clk);
    in_valid      <= 1'b1;
    operation     <= op;
    family_id     <= fam;
    genus_id      <= gen;
    species_id    <= spc;
    event_id      <= evt;
    script_handle <= hnd;
    do @(posedge clk); while (in_stall);
    shadow.apply_request(op, fam, gen, spc, evt, hnd);
  endtask

  task automatic idle(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Sends in bursts: a short or long run of back-to-back transactions,
  // then a gap that is usually short and now and then long.
  task automatic offer(input logic [OP_W-1:0] op, input logic [7:0] fam, input logic [7:0] gen,
                       input logic [15:0] spc, input logic [15:0] evt,
                       input logic [HANDLE_W-1:0] hnd);
    if (burst_left == 0) begin
      idle(($urandom_range(0, 19) == 0) ? $urandom_range(100, 280) : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    drive_request(op, fam, gen, spc, evt, hnd);
    burst_left--;
  endtask

  task automatic offer_key(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] hnd);
    offer(op, key[47:40], key[39:32], key[31:16], key[15:0], hnd);
  endtask

  // Stops offering until every predicted reply has come back.
  task automatic drain();
    idle(1);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic directed_checks();
    // Fallback on an empty table, then one entry per wildcard level.
    offer(OP_FIND_FB, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_INSTALL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(OP_INSTALL, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'h0001);
    offer(OP_INSTALL, 8'hFF, 8'h00, 16'h0000, 16'hFFFF, 16'h0002);
    offer(OP_INSTALL, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'h0003);
    offer(OP_FIND_FB, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_FIND_FB, 8'hFF, 8'hFF, 16'h1234, 16'hFFFF, 16'h0000);
    offer(OP_FIND_FB, 8'hFF, 8'h07, 16'h1234, 16'hFFFF, 16'h0000);
    offer(OP_FIND_FB, 8'h09, 8'h07, 16'h1234, 16'hFFFF, 16'h0000);
    offer(OP_FIND_EXACT, 8'hFF, 8'hFF, 16'h1234, 16'hFFFF, 16'h0000);
    // Lock twice, then install and remove are refused on the locked entry.
    offer(OP_LOCK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_LOCK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_INSTALL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0005);
    offer(OP_REMOVE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_UNLOCK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_UNLOCK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    // Replace the handle, read it back, remove twice.
    offer(OP_INSTALL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h1234);
    offer(OP_FIND_EXACT, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_REMOVE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_REMOVE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(OP_LOCK, 8'h5A, 8'hA5, 16'h5A5A, 16'hA5A5, 16'h0000);
    offer(OP_UNLOCK, 8'h5A, 8'hA5, 16'h5A5A, 16'hA5A5, 16'h0000);
    // The all-zero key, the spare code, then clear with a locked entry present.
    offer(OP_INSTALL, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    offer(OP_FIND_EXACT, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
    offer(OP_SPARE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    offer(OP_LOCK, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'h0000);
    offer(OP_CLEAR, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    offer(OP_FIND_FB, 8'h09, 8'h07, 16'h1234, 16'hFFFF, 16'h0000);
  endtask

  // Random traffic over a small key pool, so installs, locks and lookups keep
  // meeting each other; about one transaction in ten is unrestricted noise.
  task automatic random_traffic(input int count);
    logic [OP_W-1:0] op;
    logic [15:0]     spc;
    int              pick;
    for (int i = 1; i < 3; i++) begin
      pool_fam[i] = 8'($urandom);
      pool_gen[i] = 8'($urandom);
      pool_spc[i] = 16'($urandom);
    end
    pool_fam[0] = '0;
    pool_gen[0] = '0;
    pool_spc[0] = '0;
    pool_evt[0] = 16'($urandom);
    pool_evt[1] = 16'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) op = OP_INSTALL;
        else if (pick < 47) op = OP_REMOVE;
        else if (pick < 67) op = OP_FIND_FB;
        else if (pick < 77) op = OP_FIND_EXACT;
        else if (pick < 86) op = OP_LOCK;
        else if (pick < 95) op = OP_UNLOCK;
        else if (pick < 97) op = OP_CLEAR;
        else op = OP_SPARE;
        // Lookups sometimes use a species that was never installed, forcing a wildcard.
        spc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pool_spc[$urandom_range(0, 2)];
        offer(op, pool_fam[$urandom_range(0, 2)], pool_gen[$urandom_range(0, 2)], spc,
              pool_evt[$urandom_range(0, 1)], 16'($urandom));
      end
    end
  endtask

  // Fills every slot, then works on the full table: refused installs, locked
  // entries, a remove that frees one slot and an install that takes it.
  task automatic full_table_traffic();
    logic [KEY_W-1:0] keys [TABLE_ENTRIES];
    logic [KEY_W-1:0] key;
    int               pick;
    offer(OP_CLEAR, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      // The event part is unique per slot, so all keys differ.
      keys[i] = {8'($urandom), 8'($urandom), 16'($urandom), 16'(i)};
      offer_key(OP_INSTALL, keys[i], 16'($urandom));
      if ($urandom_range(0, 7) == 0) offer_key(OP_LOCK, keys[i], 16'h0000);
    end
    offer_key(OP_INSTALL, {32'($urandom), 16'hFFFF}, 16'($urandom));
    repeat (30) begin
      pick = $urandom_range(0, 99);
      key = ($urandom_range(0, 2) == 0) ? {32'($urandom), 16'($urandom)}
                                        : keys[$urandom_range(0, TABLE_ENTRIES - 1)];
      if (pick < 40) offer_key(OP_INSTALL, key, 16'($urandom));
      else if (pick < 55) offer_key(OP_REMOVE, key, 16'h0000);
      else if (pick < 70) offer_key(OP_FIND_FB, key, 16'h0000);
      else if (pick < 80) offer_key(OP_FIND_EXACT, key, 16'h0000);
      else if (pick < 90) offer_key(OP_LOCK, key, 16'h0000);
      else offer_key(OP_UNLOCK, key, 16'h0000);
    end
    offer(OP_CLEAR, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();
    random_traffic(350);
    full_table_traffic();
    drain();
    random_traffic(200);
    // Long receiver hold-off while the sender keeps offering, so the output
    // register fills and the block has to stall its input.
    holds_asked++;
    random_traffic(250);
    drain();
    random_traffic(200);

    // Wait for every reply, then one more table walk to catch stray replies.
    drain();
    repeat (SETTLE) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sctw_pkg.sv
rtl/sctw_mem.sv
rtl/script_table_with_wildcard_fallback.sv
rtl/sctw_checker.sv
sim/tb_script_table_with_wildcard_fallback.sv
